// File: hdl/dfi_term_score_macros.svh
// Assertion macros used by the port level checker of the term scoring block
`ifndef DFI_TERM_SCORE_MACROS_SVH
`define DFI_TERM_SCORE_MACROS_SVH

// Check on clk, quiet while rst_n is low
`define DTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on clk that also holds during reset
`define DTS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/dts_pkg.sv
// Shared constants, codes and sideband types of the term scoring pipeline
package dts_pkg;

    // Pipeline geometry
    localparam int SQ_STEPS  = 49;            // root bits of sqrt(expected * 2^33)
    localparam int SQ_REM_W  = SQ_STEPS + 3;  // partial remainder of the root unit
    localparam int DIV_STEPS = 64;            // quotient bits of the measure divider
    localparam int LOG_FRAC  = 24;            // fraction bits of log2
    localparam int LATENCY   = 151;           // accept edge to done sample edge

    // Largest measure value, Q32.32
    localparam logic [63:0] M_CAP = 64'hFFFF_FFFE_FFFF_FFFF;

    // Measure modes
    localparam logic [1:0] MEAS_STD  = 2'd0;
    localparam logic [1:0] MEAS_SAT  = 2'd1;
    localparam logic [1:0] MEAS_CHI  = 2'd2;
    localparam logic [1:0] MEAS_NONE = 2'd3;

    // Merge modes
    localparam logic [1:0] MERGE_REPLACE = 2'd0;
    localparam logic [1:0] MERGE_ADD     = 2'd1;
    localparam logic [1:0] MERGE_MAX     = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_MEASURE = 3'd0;
    localparam logic [2:0] REG_MERGE   = 3'd1;
    localparam logic [2:0] REG_RATIO   = 3'd2;
    localparam logic [2:0] REG_QBOOST  = 3'd3;
    localparam logic [2:0] REG_USE_DB  = 3'd4;

    // Per item sideband that rides to the end of the pipeline
    typedef struct packed {
        logic        go;
        logic [23:0] doc_boost;
        logic [31:0] prior_score;
    } dts_side_t;

    // Sideband through the root unit: difference and expected value as well
    typedef struct packed {
        dts_side_t   side;
        logic [62:0] diff;
        logic [63:0] expd;
    } dts_carry_t;

endpackage

// File: hdl/dts_sqrt.sv
// Pipelined integer square root, one root bit per stage
module dts_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [2*dts_pkg::SQ_STEPS-1:0] rad,
    input  dts_pkg::dts_carry_t           carry_in,
    output logic                          out_valid,
    output logic [dts_pkg::SQ_STEPS-1:0]  root,
    output dts_pkg::dts_carry_t           carry_out
);
    import dts_pkg::*;

    logic                  vld_reg   [SQ_STEPS];
    logic [SQ_REM_W-1:0]   rem_reg   [SQ_STEPS];
    logic [SQ_STEPS-1:0]   root_reg  [SQ_STEPS];
    logic [2*SQ_STEPS-1:0] rad_reg   [SQ_STEPS];
    dts_carry_t            carry_reg [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        logic                  vld_prev;
        logic [SQ_REM_W-1:0]   rem_prev;
        logic [SQ_STEPS-1:0]   root_prev;
        logic [2*SQ_STEPS-1:0] rad_prev;
        dts_carry_t            carry_prev;
        logic [SQ_REM_W-1:0]   rem_sh;
        logic [SQ_REM_W-1:0]   trial;
        logic                  take;

        if (k == 0) begin : g_head
            assign vld_prev   = in_valid;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign rad_prev   = rad;
            assign carry_prev = carry_in;
        end
        else begin : g_tail
            assign vld_prev   = vld_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign rad_prev   = rad_reg[k-1];
            assign carry_prev = carry_reg[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rem_sh = {rem_prev[SQ_REM_W-3:0], rad_prev[2*(SQ_STEPS-1-k) +: 2]};
        assign trial  = {1'b0, root_prev, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]   <= take ? (rem_sh - trial) : rem_sh;
            root_reg[k]  <= {root_prev[SQ_STEPS-2:0], take};
            rad_reg[k]   <= rad_prev;
            carry_reg[k] <= carry_prev;
        end
    end

    assign out_valid = vld_reg[SQ_STEPS-1];
    assign root      = root_reg[SQ_STEPS-1];
    assign carry_out = carry_reg[SQ_STEPS-1];

endmodule

// File: hdl/dts_div.sv
// Pipelined restoring divider, 128 by 64 bits, quotient saturated at the measure cap
module dts_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [127:0]        num,
    input  logic [63:0]         den,
    input  dts_pkg::dts_side_t  side_in,
    output logic                out_valid,
    output logic [63:0]         quot,
    output dts_pkg::dts_side_t  side_out
);
    import dts_pkg::*;

    // entry stage
    logic        ent_vld_reg;
    logic        ent_over_reg;
    logic [63:0] ent_rem_reg;
    logic [63:0] ent_low_reg;
    logic [63:0] ent_den_reg;
    dts_side_t   ent_side_reg;

    // step stages
    logic        vld_reg  [DIV_STEPS];
    logic        over_reg [DIV_STEPS];
    logic [63:0] rem_reg  [DIV_STEPS];
    logic [63:0] low_reg  [DIV_STEPS];
    logic [63:0] den_reg  [DIV_STEPS];
    logic [63:0] q_reg    [DIV_STEPS];
    dts_side_t   side_reg [DIV_STEPS];

    // output stage
    logic        out_vld_reg;
    logic [63:0] quot_reg;
    dts_side_t   out_side_reg;

    // Entry: quotient overflows 64 bits when the upper half reaches the divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_vld_reg <= 1'b0;
        else
            ent_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        ent_over_reg <= (num[127:64] >= den);
        ent_rem_reg  <= num[127:64];
        ent_low_reg  <= num[63:0];
        ent_den_reg  <= den;
        ent_side_reg <= side_in;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic        vld_prev;
        logic        over_prev;
        logic [63:0] rem_prev;
        logic [63:0] low_prev;
        logic [63:0] den_prev;
        logic [63:0] q_prev;
        dts_side_t   side_prev;
        logic [64:0] rem_sh;
        logic [64:0] rem_sub;
        logic        take;

        if (k == 0) begin : g_head
            assign vld_prev  = ent_vld_reg;
            assign over_prev = ent_over_reg;
            assign rem_prev  = ent_rem_reg;
            assign low_prev  = ent_low_reg;
            assign den_prev  = ent_den_reg;
            assign q_prev    = '0;
            assign side_prev = ent_side_reg;
        end
        else begin : g_tail
            assign vld_prev  = vld_reg[k-1];
            assign over_prev = over_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign low_prev  = low_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign q_prev    = q_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign rem_sh  = {rem_prev, low_prev[63]};
        assign take    = (rem_sh >= {1'b0, den_prev});
        assign rem_sub = rem_sh - {1'b0, den_prev};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            over_reg[k] <= over_prev;
            rem_reg[k]  <= take ? rem_sub[63:0] : rem_sh[63:0];
            low_reg[k]  <= {low_prev[62:0], 1'b0};
            den_reg[k]  <= den_prev;
            q_reg[k]    <= {q_prev[62:0], take};
            side_reg[k] <= side_prev;
        end
    end

    // Saturate at the cap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= vld_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        quot_reg     <= (over_reg[DIV_STEPS-1] || (q_reg[DIV_STEPS-1] > M_CAP))
                        ? M_CAP : q_reg[DIV_STEPS-1];
        out_side_reg <= side_reg[DIV_STEPS-1];
    end

    assign out_valid = out_vld_reg;
    assign quot      = quot_reg;
    assign side_out  = out_side_reg;

endmodule

// File: hdl/dts_log.sv
// Pipelined log2(1 + m) in Q5.24: normalise, then one squaring per fraction bit
module dts_log (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [63:0]         m,
    input  dts_pkg::dts_side_t  side_in,
    output logic                out_valid,
    output logic [28:0]         lg,
    output dts_pkg::dts_side_t  side_out
);
    import dts_pkg::*;

    // normalisation stages
    logic        a_vld_reg;
    logic [63:0] a_x_reg;
    dts_side_t   a_side_reg;
    logic        b_vld_reg;
    logic [63:0] b_x_reg;
    logic [4:0]  b_msb_reg;
    dts_side_t   b_side_reg;
    logic        c_vld_reg;
    logic [31:0] c_y_reg;
    logic [4:0]  c_msb_reg;
    dts_side_t   c_side_reg;
    logic [4:0]  msb_next;
    logic [5:0]  shamt;

    // squaring stages
    logic                vld_reg  [LOG_FRAC];
    logic [63:0]         p_reg    [LOG_FRAC];
    logic [LOG_FRAC-1:0] frac_reg [LOG_FRAC];
    logic [4:0]          msb_reg  [LOG_FRAC];
    dts_side_t           side_reg [LOG_FRAC];

    // output stage
    logic                o_vld_reg;
    logic [28:0]         o_lg_reg;
    dts_side_t           o_side_reg;

    // Leading one of the upper word (x is at least 2^32)
    always_comb
    begin
        msb_next = '0;
        for (int i = 0; i < 32; i++) begin
            if (a_x_reg[32+i])
                msb_next = 5'(i);
        end
    end

    assign shamt = {1'b0, b_msb_reg} + 6'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_x_reg    <= m + 64'h1_0000_0000;
        a_side_reg <= side_in;
        b_x_reg    <= a_x_reg;
        b_msb_reg  <= msb_next;
        b_side_reg <= a_side_reg;
        // mantissa in Q1.31
        c_y_reg    <= 32'(b_x_reg >> shamt);
        c_msb_reg  <= b_msb_reg;
        c_side_reg <= b_side_reg;
    end

    for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
        logic                vld_prev;
        logic [4:0]          msb_prev;
        dts_side_t           side_prev;
        logic [LOG_FRAC-1:0] frac_prev;
        logic [31:0]         ys;
        logic                fbit;

        if (k == 0) begin : g_head
            assign vld_prev  = c_vld_reg;
            assign msb_prev  = c_msb_reg;
            assign side_prev = c_side_reg;
            assign frac_prev = '0;
            assign fbit      = 1'b0;
            assign ys        = c_y_reg;
        end
        else begin : g_tail
            // square reached two: take the bit and halve
            assign vld_prev  = vld_reg[k-1];
            assign msb_prev  = msb_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign fbit      = p_reg[k-1][63];
            assign frac_prev = {frac_reg[k-1][LOG_FRAC-2:0], fbit};
            assign ys        = fbit ? p_reg[k-1][63:32] : p_reg[k-1][62:31];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            p_reg[k]    <= 64'(ys) * 64'(ys);
            frac_reg[k] <= frac_prev;
            msb_reg[k]  <= msb_prev;
            side_reg[k] <= side_prev;
        end
    end

    // Last fraction bit and assembly
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else
            o_vld_reg <= vld_reg[LOG_FRAC-1];
    end

    always_ff @(posedge clk)
    begin
        o_lg_reg   <= {msb_reg[LOG_FRAC-1], frac_reg[LOG_FRAC-1][LOG_FRAC-2:0],
                       p_reg[LOG_FRAC-1][63]};
        o_side_reg <= side_reg[LOG_FRAC-1];
    end

    assign out_valid = o_vld_reg;
    assign lg        = o_lg_reg;
    assign side_out  = o_side_reg;

endmodule

// File: hdl/dfi_term_score.sv
// Top level: divergence-from-independence term scoring pipeline
//
//  channel   direction  handshake           payload
//  item in   in         start / busy        term_freq, doc_length, doc_boost, prior_score
//  result    out        done (one cycle)    score
//  config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle, every cycle; busy stays low and cfg_ready stays high.
// The pipeline depth comes from the front and back stages, the 49-stage root unit,
// the divider with its 64 step stages and the 24 squaring stages of the log unit.
// Reset clears the valid bits and loads the register defaults; payload is not reset.
// The result receiver cannot stall, and the pipeline never needs to.
module dfi_term_score (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] term_freq,
    input  logic [31:0] doc_length,
    input  logic [23:0] doc_boost,
    input  logic [31:0] prior_score,
    output logic        done,
    output logic [31:0] score,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import dts_pkg::*;

    // configuration
    logic [1:0]  measure_mode_reg;
    logic [1:0]  merge_mode_reg;
    logic [31:0] term_ratio_reg;
    logic [23:0] query_boost_reg;
    logic        use_doc_boost_reg;

    // front stages
    logic        f1_vld_reg;
    logic [63:0] f1_e_reg;
    logic [31:0] f1_tf_reg;
    logic [23:0] f1_db_reg;
    logic [31:0] f1_prior_reg;
    logic        f2_vld_reg;
    dts_carry_t  f2_carry_reg;
    logic [62:0] t_val;
    logic        go_next;

    // root unit
    logic                sq_vld;
    logic [SQ_STEPS-1:0] sq_root;
    dts_carry_t          sq_carry;

    // numerator stages
    logic                n1_vld_reg;
    logic [63:0]         n1_ll_reg;
    logic [62:0]         n1_lh_reg;
    logic [61:0]         n1_hh_reg;
    logic [SQ_STEPS-1:0] n1_root_reg;
    dts_carry_t          n1_carry_reg;
    logic                n2_vld_reg;
    logic [127:0]        n2_num_reg;
    logic [63:0]         n2_den_reg;
    dts_side_t           n2_side_reg;
    logic [127:0]        sq_sum;
    logic [127:0]        num_next;
    logic [63:0]         den_next;

    // divider and log units
    logic        dv_vld;
    logic [63:0] dv_quot;
    dts_side_t   dv_side;
    logic        lg_vld;
    logic [28:0] lg_val;
    dts_side_t   lg_side;

    // back stages
    logic        b1_vld_reg;
    logic [28:0] b1_lg_reg;
    logic [47:0] b1_boost_reg;
    logic [31:0] b1_prior_reg;
    logic        b2_vld_reg;
    logic [52:0] b2_plo_reg;
    logic [52:0] b2_phi_reg;
    logic [31:0] b2_prior_reg;
    logic        b3_vld_reg;
    logic [31:0] b3_term_reg;
    logic [31:0] b3_prior_reg;
    logic        done_reg;
    logic [31:0] score_reg;
    logic [77:0] prod_sum;
    logic [37:0] term_wide;
    logic [32:0] add_sum;
    logic [31:0] score_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            measure_mode_reg  <= MEAS_STD;
            merge_mode_reg    <= MERGE_REPLACE;
            term_ratio_reg    <= 32'h8000_0000;
            query_boost_reg   <= 24'h01_0000;
            use_doc_boost_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MEASURE: measure_mode_reg  <= cfg_data[1:0];
                REG_MERGE:   merge_mode_reg    <= cfg_data[1:0];
                REG_RATIO:   term_ratio_reg    <= cfg_data;
                REG_QBOOST:  query_boost_reg   <= cfg_data[23:0];
                REG_USE_DB:  use_doc_boost_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // F1: expected = ratio * length; F2: difference and score gate
    assign t_val   = {f1_tf_reg, 31'b0};
    assign go_next = (f1_e_reg != 64'd0) && ({1'b0, t_val} > f1_e_reg)
                     && (measure_mode_reg != MEAS_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else begin
            f1_vld_reg <= start && !busy;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_e_reg                      <= 64'(term_ratio_reg) * 64'(doc_length);
        f1_tf_reg                     <= term_freq;
        f1_db_reg                     <= doc_boost;
        f1_prior_reg                  <= prior_score;
        f2_carry_reg.side.go          <= go_next;
        f2_carry_reg.side.doc_boost   <= f1_db_reg;
        f2_carry_reg.side.prior_score <= f1_prior_reg;
        f2_carry_reg.diff             <= t_val - f1_e_reg[62:0];
        f2_carry_reg.expd             <= f1_e_reg;
    end

    // Root of expected * 2^33
    dts_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f2_vld_reg),
        .rad       ({1'b0, f2_carry_reg.expd, 33'b0}),
        .carry_in  (f2_carry_reg),
        .out_valid (sq_vld),
        .root      (sq_root),
        .carry_out (sq_carry)
    );

    // N1: partial products of diff squared; N2: numerator and divisor by mode
    assign sq_sum = 128'(n1_ll_reg) + (128'(n1_lh_reg) << 33) + (128'(n1_hh_reg) << 64);

    always_comb
    begin
        case (measure_mode_reg)
            MEAS_STD: begin
                num_next = {32'b0, n1_carry_reg.diff, 33'b0};
                den_next = {15'b0, n1_root_reg};
            end
            MEAS_SAT: begin
                num_next = {33'b0, n1_carry_reg.diff, 32'b0};
                den_next = n1_carry_reg.expd;
            end
            MEAS_CHI: begin
                num_next = {sq_sum[126:0], 1'b0};
                den_next = n1_carry_reg.expd;
            end
            default: begin
                num_next = '0;
                den_next = n1_carry_reg.expd;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            n1_vld_reg <= 1'b0;
            n2_vld_reg <= 1'b0;
        end
        else begin
            n1_vld_reg <= sq_vld;
            n2_vld_reg <= n1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n1_ll_reg    <= 64'(sq_carry.diff[31:0]) * 64'(sq_carry.diff[31:0]);
        n1_lh_reg    <= 63'(sq_carry.diff[31:0]) * 63'(sq_carry.diff[62:32]);
        n1_hh_reg    <= 62'(sq_carry.diff[62:32]) * 62'(sq_carry.diff[62:32]);
        n1_root_reg  <= sq_root;
        n1_carry_reg <= sq_carry;
        n2_num_reg   <= num_next;
        n2_den_reg   <= den_next;
        n2_side_reg  <= n1_carry_reg.side;
    end

    // Measure division
    dts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n2_vld_reg),
        .num       (n2_num_reg),
        .den       (n2_den_reg),
        .side_in   (n2_side_reg),
        .out_valid (dv_vld),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    // log2(1 + measure)
    dts_log u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_vld),
        .m         (dv_quot),
        .side_in   (dv_side),
        .out_valid (lg_vld),
        .lg        (lg_val),
        .side_out  (lg_side)
    );

    // B3: round half up at bit 40, saturate to 32 bits
    assign prod_sum  = 78'(b2_plo_reg) + (78'(b2_phi_reg) << 24) + (78'(1) << 39);
    assign term_wide = prod_sum[77:40];

    // B4: merge with the prior score
    assign add_sum = 33'(b3_prior_reg) + 33'(b3_term_reg);

    always_comb
    begin
        case (merge_mode_reg)
            MERGE_ADD: score_next = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
            MERGE_MAX: score_next = (b3_term_reg > b3_prior_reg) ? b3_term_reg : b3_prior_reg;
            default:   score_next = b3_term_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else begin
            b1_vld_reg <= lg_vld;
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
            done_reg   <= b3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // B1: gate the log, form the boost in Q.32
        b1_lg_reg    <= lg_side.go ? lg_val : 29'd0;
        b1_boost_reg <= use_doc_boost_reg
                        ? 48'(query_boost_reg) * 48'(lg_side.doc_boost)
                        : {8'b0, query_boost_reg, 16'b0};
        b1_prior_reg <= lg_side.prior_score;
        // B2: log times boost in two halves
        b2_plo_reg   <= 53'(b1_lg_reg) * 53'(b1_boost_reg[23:0]);
        b2_phi_reg   <= 53'(b1_lg_reg) * 53'(b1_boost_reg[47:24]);
        b2_prior_reg <= b1_prior_reg;
        b3_term_reg  <= (term_wide[37:32] != 6'd0) ? 32'hFFFF_FFFF : term_wide[31:0];
        b3_prior_reg <= b2_prior_reg;
        score_reg    <= score_next;
    end

    assign done  = done_reg;
    assign score = score_reg;

endmodule

// File: hdl/dfi_term_score_chk.sv
// Port level checker for the term scoring block, bound to the top level
`include "dfi_term_score_macros.svh"

module dfi_term_score_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done
);
    import dts_pkg::*;

    // no result strobe while in reset
    `DTS_ASSERT_RST(a_quiet_in_reset, !rst_n |-> !done, "done high during reset")

    // every result comes from an item taken a fixed latency earlier
    `DTS_ASSERT(a_done_latency, done |-> $past(start && !busy, LATENCY), "result without item")

    // the pipeline never refuses an item
    `DTS_ASSERT(a_never_busy, start |-> !busy, "item refused")

endmodule

bind dfi_term_score dfi_term_score_chk u_chk (.*);
